>>> rtl/core/mhs_pkg.sv
// shared types and constants for the minhash signature engine
package mhs_pkg;

  localparam int MAX_HASHES  = 8;
  localparam int SLOT_W      = 3;
  localparam int VERTEX_BITS = 20;
  localparam int WORD_W      = 31;
  localparam int CNT_W       = 4;
  localparam int PROD_W      = WORD_W + VERTEX_BITS;
  localparam int SUM_W       = PROD_W + 1;
  localparam int FOLD_W      = WORD_W + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [WORD_W-1:0] MERSENNE_P   = {WORD_W{1'b1}};
  localparam logic [CNT_W-1:0]  HASHES_RESET = 4'd8;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_HASH = 1'b1
  } func_e;

  typedef struct packed {
    logic                   is_load;
    logic [SLOT_W-1:0]      slot;
    logic [WORD_W-1:0]      mult;
    logic [WORD_W-1:0]      add;
    logic [VERTEX_BITS-1:0] id;
    logic                   last;
  } cmd_t;

  typedef struct packed {
    logic                               valid;
    logic [CNT_W-1:0]                   count;
    logic [MAX_HASHES-1:0][WORD_W-1:0]  words;
  } sig_t;

endpackage

>>> rtl/core/mhs_front.sv
// front end: accepts input words, classifies them and queues commands for the hash lanes
module mhs_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic                            func_i,
  input  logic [mhs_pkg::SLOT_W-1:0]      coeff_slot_i,
  input  logic [mhs_pkg::WORD_W-1:0]      coeff_mult_i,
  input  logic [mhs_pkg::WORD_W-1:0]      coeff_add_i,
  input  logic [mhs_pkg::VERTEX_BITS-1:0] vertex_id_i,
  input  logic                            last_i,
  output logic                            cmd_valid_o,
  output mhs_pkg::cmd_t                   cmd_o,
  input  logic                            cmd_pop_i
);
  import mhs_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              accept;
  logic              slot_ok;
  logic              keep;
  cmd_t              cmd_in;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign accept  = push_i & ~full_o;
  // loads to a slot beyond the table are dropped here
  assign slot_ok = (int'(coeff_slot_i) < MAX_HASHES);
  assign keep    = accept & ((func_i == FUNC_HASH) | slot_ok);

  always_comb begin
    cmd_in.is_load = (func_i == FUNC_LOAD);
    cmd_in.slot    = coeff_slot_i;
    cmd_in.mult    = coeff_mult_i;
    cmd_in.add     = coeff_add_i;
    cmd_in.id      = vertex_id_i;
    cmd_in.last    = last_i;
  end

  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = keep      ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    unique case ({keep, cmd_pop_i})
      2'b10:   cnt_d = cnt_q + (QPTR_W+1)'(1);
      2'b01:   cnt_d = cnt_q - (QPTR_W+1)'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

>>> rtl/core/mhs_hash_lanes.sv
// back end: coefficient tables, per-slot multiply, mersenne reduction and running minima
module mhs_hash_lanes (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  mhs_pkg::cmd_t              cmd_i,
  output logic                       cmd_pop_o,
  input  logic [mhs_pkg::CNT_W-1:0]  n_active_i,
  input  logic                       sig_free_i,
  output mhs_pkg::sig_t              sig_o
);
  import mhs_pkg::*;

  logic [WORD_W-1:0] mult_q [MAX_HASHES];
  logic [WORD_W-1:0] add_q  [MAX_HASHES];
  logic [WORD_W-1:0] min_q  [MAX_HASHES];

  logic              s1_valid_q, s1_last_q;
  logic [PROD_W-1:0] s1_prod_q [MAX_HASHES];
  logic [WORD_W-1:0] s1_offs_q [MAX_HASHES];

  logic              s2_valid_q, s2_last_q;
  logic [FOLD_W-1:0] s2_fold_q [MAX_HASHES];

  logic              s3_valid_q, s3_last_q;
  logic [WORD_W-1:0] s3_hash_q [MAX_HASHES];

  logic              adv;
  logic              hash_go;
  logic              load_go;
  logic              retire;
  logic [SUM_W-1:0]  sum    [MAX_HASHES];
  logic [FOLD_W-1:0] fold   [MAX_HASHES];
  logic [FOLD_W-1:0] folded [MAX_HASHES];
  logic [FOLD_W-1:0] reduced[MAX_HASHES];
  logic [WORD_W-1:0] cand   [MAX_HASHES];
  logic [MAX_HASHES-1:0] active;

  // a flagged id waits in the last stage until the output buffer is free
  assign adv       = ~(s3_valid_q & s3_last_q & ~sig_free_i);
  assign cmd_pop_o = cmd_valid_i & adv;
  assign load_go   = cmd_pop_o & cmd_i.is_load;
  assign hash_go   = cmd_pop_o & ~cmd_i.is_load;
  assign retire    = adv & s3_valid_q;

  always_comb begin
    for (int i = 0; i < MAX_HASHES; i++) begin
      sum[i]     = SUM_W'(s1_prod_q[i]) + SUM_W'(s1_offs_q[i]);
      // 2^31 == 1 mod p, so fold the high part onto the low part
      fold[i]    = FOLD_W'(sum[i][SUM_W-1:WORD_W]) + FOLD_W'(sum[i][WORD_W-1:0]);
      folded[i]  = FOLD_W'(s2_fold_q[i][WORD_W-1:0]) + FOLD_W'(s2_fold_q[i][WORD_W]);
      reduced[i] = (folded[i] >= FOLD_W'(MERSENNE_P)) ? folded[i] - FOLD_W'(MERSENNE_P)
                                                      : folded[i];
      active[i]  = (CNT_W'(i) < n_active_i);
      cand[i]    = (s3_hash_q[i] < min_q[i]) ? s3_hash_q[i] : min_q[i];
    end
  end

  always_comb begin
    sig_o.valid = retire & s3_last_q;
    sig_o.count = n_active_i;
    for (int i = 0; i < MAX_HASHES; i++) begin
      sig_o.words[i] = active[i] ? cand[i] : MERSENNE_P;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_go) begin
      mult_q[cmd_i.slot] <= cmd_i.mult;
      add_q[cmd_i.slot]  <= cmd_i.add;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_last_q <= cmd_i.last;
      s2_last_q <= s1_last_q;
      s3_last_q <= s2_last_q;
      for (int i = 0; i < MAX_HASHES; i++) begin
        s1_prod_q[i] <= PROD_W'(mult_q[i]) * PROD_W'(cmd_i.id);
        s1_offs_q[i] <= add_q[i];
        s2_fold_q[i] <= fold[i];
        s3_hash_q[i] <= WORD_W'(reduced[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= hash_go;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_HASHES; i++) begin
        min_q[i] <= MERSENNE_P;
      end
    end else if (retire) begin
      for (int i = 0; i < MAX_HASHES; i++) begin
        if (s3_last_q) begin
          min_q[i] <= MERSENNE_P;
        end else if (active[i]) begin
          min_q[i] <= cand[i];
        end
      end
    end
  end

endmodule

>>> rtl/core/mhs_sig_out.sv
// output buffer: holds one finished signature and hands it out a word at a time
module mhs_sig_out (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mhs_pkg::sig_t               sig_i,
  output logic                        sig_free_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [mhs_pkg::SLOT_W-1:0]  hash_slot_o,
  output logic [mhs_pkg::WORD_W-1:0]  min_value_o,
  output logic                        last_of_signature_o
);
  import mhs_pkg::*;

  logic [WORD_W-1:0] words_q [MAX_HASHES];
  logic              busy_q;
  logic [SLOT_W-1:0] idx_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              take;
  logic              last_word;
  logic              done;

  assign take       = pop_i & busy_q;
  assign last_word  = (idx_q == SLOT_W'(cnt_q - CNT_W'(1)));
  assign done       = take & last_word;
  assign sig_free_o = ~busy_q | done;

  assign empty_o             = ~busy_q;
  assign hash_slot_o         = idx_q;
  assign min_value_o         = words_q[idx_q];
  assign last_of_signature_o = last_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      cnt_q  <= '0;
    end else if (sig_i.valid) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      cnt_q  <= sig_i.count;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (take) begin
      idx_q <= idx_q + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sig_i.valid) begin
      for (int i = 0; i < MAX_HASHES; i++) begin
        words_q[i] <= sig_i.words[i];
      end
    end
  end

endmodule

>>> rtl/core/minhash_signature_engine.sv
// MinHash signature engine top level: slot count register, front queue, hash lanes, output buffer
//
// Loads a multiplier and offset per hash slot, then takes one word per clock while full is low: a coefficient
// load or a vertex id. Every id is hashed in all slots in use as (a*id+b) mod 2^31-1 by eight
// parallel lanes (a 31x20 multiply, a fold and a final subtract, three register stages) and the
// running minimum per slot is kept. On the id flagged last, one word per slot in use comes out,
// slot 0 first, the final one marked, and the minima return to 2^31-1. Ids and loads are
// accepted at one word per cycle while the queue is not full; the single signature buffer
// hands out one word per pop (n words, n = slots in use, 1..8), and a following flagged id
// waits in the last lane stage until that buffer drains. A four-entry queue sits between the
// input and the lanes. A flagged id passes through the queue, the three lane stages and the
// output buffer before its first word is on the result ports. The slot count register is
// sampled live; write it only while idle.
// Hashing a slot whose coefficients were never loaded gives an undefined result.
module minhash_signature_engine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic                            func_i,
  input  logic [mhs_pkg::SLOT_W-1:0]      coeff_slot_i,
  input  logic [mhs_pkg::WORD_W-1:0]      coeff_mult_i,
  input  logic [mhs_pkg::WORD_W-1:0]      coeff_add_i,
  input  logic [mhs_pkg::VERTEX_BITS-1:0] vertex_id_i,
  input  logic                            last_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [mhs_pkg::SLOT_W-1:0]      hash_slot_o,
  output logic [mhs_pkg::WORD_W-1:0]      min_value_o,
  output logic                            last_of_signature_o,
  input  logic                            cfg_we_i,
  input  logic [mhs_pkg::CNT_W-1:0]       cfg_wdata_i
);
  import mhs_pkg::*;

  logic [CNT_W-1:0] hashes_q;
  logic [CNT_W-1:0] n_active;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;
  sig_t             sig;
  logic             sig_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hashes_q <= HASHES_RESET;
    end else if (cfg_we_i) begin
      hashes_q <= cfg_wdata_i;
    end
  end

  // zero acts as one slot, anything above the lane count as all lanes
  always_comb begin
    priority if (hashes_q == '0) begin
      n_active = CNT_W'(1);
    end else if (hashes_q > CNT_W'(MAX_HASHES)) begin
      n_active = CNT_W'(MAX_HASHES);
    end else begin
      n_active = hashes_q;
    end
  end

  mhs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .func_i       (func_i),
    .coeff_slot_i (coeff_slot_i),
    .coeff_mult_i (coeff_mult_i),
    .coeff_add_i  (coeff_add_i),
    .vertex_id_i  (vertex_id_i),
    .last_i       (last_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  mhs_hash_lanes u_lanes (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .n_active_i  (n_active),
    .sig_free_i  (sig_free),
    .sig_o       (sig)
  );

  mhs_sig_out u_out (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .sig_i               (sig),
    .sig_free_o          (sig_free),
    .empty_o             (empty),
    .pop_i               (pop),
    .hash_slot_o         (hash_slot_o),
    .min_value_o         (min_value_o),
    .last_of_signature_o (last_of_signature_o)
  );

endmodule

>>> bench/tb.sv
// testbench for the minhash signature engine: directed table, then random runs vs a predictor
`timescale 1ns / 1ps

module tb;
  import mhs_pkg::*;

  localparam int TOTAL_ITEMS   = 500;
  localparam int CALM_ITEMS    = 60;
  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_LIMIT   = 2000;
  localparam int N_DIR         = 25;

  typedef enum logic [1:0] {
    ROW_WORD,
    ROW_CFG,
    ROW_SETTLE
  } row_kind_e;

  typedef struct {
    row_kind_e              kind;
    func_e                  func;
    logic [SLOT_W-1:0]      slot;
    logic [WORD_W-1:0]      mult;
    logic [WORD_W-1:0]      add;
    logic [VERTEX_BITS-1:0] id;
    logic                   last;
    logic [CNT_W-1:0]       cfg;
    logic                   pinned;
    logic [WORD_W-1:0]      pinned_min;
  } stim_row_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] min_value;
    logic              tail;
  } sig_word_t;

  logic                   clk_i;
  logic                   rst_ni       = 1'b0;
  logic                   push         = 1'b0;
  logic                   func_i       = 1'b0;
  logic [SLOT_W-1:0]      coeff_slot_i = '0;
  logic [WORD_W-1:0]      coeff_mult_i = '0;
  logic [WORD_W-1:0]      coeff_add_i  = '0;
  logic [VERTEX_BITS-1:0] vertex_id_i  = '0;
  logic                   last_i       = 1'b0;
  logic                   pop          = 1'b0;
  logic                   cfg_we_i     = 1'b0;
  logic [CNT_W-1:0]       cfg_wdata_i  = '0;
  logic                   full;
  logic                   empty;
  logic [SLOT_W-1:0]      hash_slot_o;
  logic [WORD_W-1:0]      min_value_o;
  logic                   last_of_signature_o;

  // predictor state
  logic [WORD_W-1:0] coeff_mult_q [MAX_HASHES];
  logic [WORD_W-1:0] coeff_add_q  [MAX_HASHES];
  logic [WORD_W-1:0] slot_min_q   [MAX_HASHES];
  logic [CNT_W-1:0]  hashes_q;
  sig_word_t         sig_expect [$];

  stim_row_t   dir_rows [N_DIR];
  sig_word_t   head_word;
  int          errors       = 0;
  int          items        = 0;
  bit          calm         = 1'b0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;

  minhash_signature_engine uut (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .func_i,
    .coeff_slot_i,
    .coeff_mult_i,
    .coeff_add_i,
    .vertex_id_i,
    .last_i,
    .empty,
    .pop,
    .hash_slot_o,
    .min_value_o,
    .last_of_signature_o,
    .cfg_we_i,
    .cfg_wdata_i
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [WORD_W-1:0] mersenne_hash(input int s,
                                                      input logic [VERTEX_BITS-1:0] id);
    longint unsigned a;
    longint unsigned b;
    longint unsigned v;
    a = coeff_mult_q[s];
    b = coeff_add_q[s];
    v = a * longint'(id) + b;
    return WORD_W'(v % longint'(MERSENNE_P));
  endfunction

  task automatic predict_signature(input stim_row_t r);
    int        n;
    sig_word_t w;
    if (r.func == FUNC_LOAD) begin
      coeff_mult_q[r.slot] = r.mult;
      coeff_add_q[r.slot]  = r.add;
    end else begin
      // zero acts as one slot, anything above the table size as all of them
      n = (hashes_q == 0) ? 1 : (hashes_q > MAX_HASHES) ? MAX_HASHES : int'(hashes_q);
      for (int i = 0; i < n; i++) begin
        if (mersenne_hash(i, r.id) < slot_min_q[i]) slot_min_q[i] = mersenne_hash(i, r.id);
      end
      if (r.last) begin
        for (int i = 0; i < n; i++) begin
          w.slot      = SLOT_W'(i);
          w.min_value = (i == 0 && r.pinned) ? r.pinned_min : slot_min_q[i];
          w.tail      = (i == n - 1);
          sig_expect  = {sig_expect, w};
        end
        foreach (slot_min_q[i]) slot_min_q[i] = MERSENNE_P;
      end
    end
  endtask

  task automatic send_row(input stim_row_t r);
    push         <= 1'b1;
    func_i       <= r.func;
    coeff_slot_i <= r.slot;
    coeff_mult_i <= r.mult;
    coeff_add_i  <= r.add;
    vertex_id_i  <= r.id;
    last_i       <= r.last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_signature(r);
    items++;
    calm = (items >= TOTAL_ITEMS - CALM_ITEMS);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // wait for every signature word, then let trailing ids clear the lanes
  task automatic settle();
    push <= 1'b0;
    while (sig_expect.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_hashes(input logic [CNT_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hashes_q = v;
  endtask

  function automatic logic [CNT_W-1:0] pick_hashes();
    case ($urandom_range(0, 5))
      0:       return 4'd0;
      1:       return 4'd1;
      2:       return 4'd8;
      3:       return 4'd15;
      default: return CNT_W'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic stim_row_t rand_load(input logic [SLOT_W-1:0] s);
    stim_row_t r;
    r.kind = ROW_WORD;
    r.func = FUNC_LOAD;
    r.slot = s;
    case ($urandom_range(0, 9))
      0:       r.mult = '0;
      1:       r.mult = MERSENNE_P;
      default: r.mult = WORD_W'($urandom_range(1, 32'h7FFF_FFFE));
    endcase
    case ($urandom_range(0, 9))
      0:       r.add = '0;
      1:       r.add = MERSENNE_P;
      default: r.add = WORD_W'($urandom());
    endcase
    r.id         = VERTEX_BITS'($urandom());
    r.last       = 1'($urandom());
    r.cfg        = '0;
    r.pinned     = 1'b0;
    r.pinned_min = '0;
    return r;
  endfunction

  function automatic stim_row_t rand_feed(input logic is_last);
    stim_row_t r;
    r.kind = ROW_WORD;
    r.func = FUNC_HASH;
    r.slot = SLOT_W'($urandom());
    r.mult = WORD_W'($urandom());
    r.add  = WORD_W'($urandom());
    case ($urandom_range(0, 7))
      0:       r.id = VERTEX_BITS'($urandom_range(0, 15));
      1:       r.id = '1;
      2:       r.id = '0;
      default: r.id = VERTEX_BITS'($urandom());
    endcase
    r.last       = is_last;
    r.cfg        = '0;
    r.pinned     = 1'b0;
    r.pinned_min = '0;
    return r;
  endfunction

  initial begin
    int run_len;

    // every slot is loaded before the first id so no hash reads an unwritten pair
    dir_rows[0]  = '{ROW_WORD, FUNC_LOAD, 3'd0, 31'd1, 31'd0, 20'd0, 1'b0, 4'd0, 1'b0, 31'd0};
    dir_rows[1]  = '{ROW_WORD, FUNC_LOAD, 3'd1, 31'h7FFF_FFFE, 31'h7FFF_FFFF, 20'hFFFFF, 1'b1,
                     4'd0, 1'b0, 31'd0};
    dir_rows[2]  = '{ROW_WORD, FUNC_LOAD, 3'd2, 31'd0, 31'h7FFF_FFFF, 20'd0, 1'b0, 4'd0, 1'b0,
                     31'd0};
    dir_rows[3]  = '{ROW_WORD, FUNC_LOAD, 3'd3, 31'h7FFF_FFFF, 31'd5, 20'd0, 1'b0, 4'd0, 1'b0,
                     31'd0};
    dir_rows[4]  = '{ROW_WORD, FUNC_LOAD, 3'd4, 31'd1, 31'h7FFF_FFFE, 20'd0, 1'b0, 4'd0, 1'b0,
                     31'd0};
    dir_rows[5]  = '{ROW_WORD, FUNC_LOAD, 3'd5, 31'd48271, 31'd0, 20'd0, 1'b0, 4'd0, 1'b0, 31'd0};
    dir_rows[6]  = '{ROW_WORD, FUNC_LOAD, 3'd6, 31'd16807, 31'd12345, 20'd0, 1'b0, 4'd0, 1'b0,
                     31'd0};
    dir_rows[7]  = '{ROW_WORD, FUNC_LOAD, 3'd7, 31'h5555_5555, 31'h2AAA_AAAA, 20'd0, 1'b0, 4'd0,
                     1'b0, 31'd0};
    // slot 0 hashes to the id itself, so its minimum is plain to see
    dir_rows[8]  = '{ROW_WORD, FUNC_HASH, 3'd7, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 20'hFFFFF, 1'b0,
                     4'd0, 1'b0, 31'd0};
    dir_rows[9]  = '{ROW_WORD, FUNC_HASH, 3'd0, 31'd0, 31'd0, 20'd0, 1'b0, 4'd0, 1'b0, 31'd0};
    dir_rows[10] = '{ROW_WORD, FUNC_HASH, 3'd0, 31'd0, 31'd0, 20'd12345, 1'b1, 4'd0, 1'b1, 31'd0};
    dir_rows[11] = '{ROW_SETTLE, FUNC_LOAD, 3'd0, 31'd0, 31'd0, 20'd0, 1'b0, 4'd0, 1'b0, 31'd0};
    dir_rows[12] = '{ROW_CFG, FUNC_LOAD, 3'd0, 31'd0, 31'd0, 20'd0, 1'b0, 4'd0, 1'b0, 31'd0};
    dir_rows[13] = '{ROW_WORD, FUNC_HASH, 3'd0, 31'd0, 31'd0, 20'd700, 1'b0, 4'd0, 1'b0, 31'd0};
    dir_rows[14] = '{ROW_WORD, FUNC_HASH, 3'd0, 31'd0, 31'd0, 20'd300, 1'b1, 4'd0, 1'b1,
                     31'd300};
    dir_rows[15] = '{ROW_SETTLE, FUNC_LOAD, 3'd0, 31'd0, 31'd0, 20'd0, 1'b0, 4'd0, 1'b0, 31'd0};
    dir_rows[16] = '{ROW_CFG, FUNC_LOAD, 3'd0, 31'd0, 31'd0, 20'd0, 1'b0, 4'd15, 1'b0, 31'd0};
    dir_rows[17] = '{ROW_WORD, FUNC_HASH, 3'd0, 31'd0, 31'd0, 20'hFFFFF, 1'b1, 4'd0, 1'b1,
                     31'hFFFFF};
    dir_rows[18] = '{ROW_SETTLE, FUNC_LOAD, 3'd0, 31'd0, 31'd0, 20'd0, 1'b0, 4'd0, 1'b0, 31'd0};
    // slots 1 and 2 join in the middle of this run
    dir_rows[19] = '{ROW_CFG, FUNC_LOAD, 3'd0, 31'd0, 31'd0, 20'd0, 1'b0, 4'd1, 1'b0, 31'd0};
    dir_rows[20] = '{ROW_WORD, FUNC_HASH, 3'd0, 31'd0, 31'd0, 20'd50, 1'b0, 4'd0, 1'b0, 31'd0};
    dir_rows[21] = '{ROW_SETTLE, FUNC_LOAD, 3'd0, 31'd0, 31'd0, 20'd0, 1'b0, 4'd0, 1'b0, 31'd0};
    dir_rows[22] = '{ROW_CFG, FUNC_LOAD, 3'd0, 31'd0, 31'd0, 20'd0, 1'b0, 4'd3, 1'b0, 31'd0};
    dir_rows[23] = '{ROW_WORD, FUNC_HASH, 3'd0, 31'd0, 31'd0, 20'd900, 1'b1, 4'd0, 1'b1, 31'd50};
    dir_rows[24] = '{ROW_SETTLE, FUNC_LOAD, 3'd0, 31'd0, 31'd0, 20'd0, 1'b0, 4'd0, 1'b0, 31'd0};

    foreach (slot_min_q[i]) begin
      coeff_mult_q[i] = '0;
      coeff_add_q[i]  = '0;
      slot_min_q[i]   = MERSENNE_P;
    end
    hashes_q = HASHES_RESET;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_WORD: begin
          sender_gap();
          send_row(dir_rows[i]);
        end
        ROW_CFG:    write_hashes(dir_rows[i].cfg);
        ROW_SETTLE: settle();
        default:    ;
      endcase
    end

    while (items < TOTAL_ITEMS) begin
      settle();
      write_hashes(pick_hashes());
      repeat ($urandom_range(0, 3)) begin
        sender_gap();
        send_row(rand_load(SLOT_W'($urandom())));
      end
      repeat ($urandom_range(2, 6)) begin
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
        for (int k = 0; k < run_len; k++) begin
          // coefficient reload in the middle of a run
          if ($urandom_range(0, 11) == 0) begin
            sender_gap();
            send_row(rand_load(SLOT_W'($urandom())));
          end
          sender_gap();
          send_row(rand_feed(k == run_len - 1));
        end
      end
      // leave a run open across the next slot count change now and then
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          sender_gap();
          send_row(rand_feed(1'b0));
        end
      end
    end

    settle();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // result side: check each popped word, stall in bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (sig_expect.size() == 0) begin
          $error("unexpected word: hash_slot %0d min_value %0h", hash_slot_o, min_value_o);
          errors++;
        end else begin
          head_word = sig_expect.pop_front();
          if (hash_slot_o !== head_word.slot) begin
            $error("hash_slot: expected %0d, got %0d", head_word.slot, hash_slot_o);
            errors++;
          end
          if (min_value_o !== head_word.min_value) begin
            $error("min_value: expected %0h, got %0h", head_word.min_value, min_value_o);
            errors++;
          end
          if (last_of_signature_o !== head_word.tail) begin
            $error("last_of_signature: expected %0b, got %0b", head_word.tail,
                   last_of_signature_o);
            errors++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

>>> filelist.f
rtl/core/mhs_pkg.sv
rtl/core/mhs_front.sv
rtl/core/mhs_hash_lanes.sv
rtl/core/mhs_sig_out.sv
rtl/core/minhash_signature_engine.sv
bench/tb.sv
